[rtl/rcf_pkg.sv]
// ============================================================================
// rcf_pkg - shared types, palette and channel helpers for the color fader
// Holds the fixed palette, the divider request/response structs and the
// controller state type.
// ============================================================================
`default_nettype none

package rcf_pkg;

    localparam int unsigned STEP_W  = 16;
    localparam int unsigned SEG_W   = 4;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned CHAN_W  = 8;

    localparam logic [COLOR_W-1:0] WORK_COLOR = 32'h0000_FF00;

    // Register indexes on the configuration port
    localparam logic CFG_FLOW_STEPS = 1'b0;
    localparam logic CFG_WORK_STEPS = 1'b1;

    localparam logic [STEP_W-1:0] FLOW_STEPS_RST = 16'd1000;
    localparam logic [STEP_W-1:0] WORK_STEPS_RST = 16'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] k;
        logic [STEP_W-1:0] n;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] quot;
        logic              rem_nz;
    } t_div_res;

    function automatic logic [COLOR_W-1:0] palette(input logic [SEG_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            4'd0:    c = 32'hFF00_00FF;
            4'd1:    c = 32'h0000_FF00;
            4'd2:    c = 32'hFFFF_0000;
            4'd3:    c = 32'h0000_00FF;
            4'd4:    c = 32'hFF00_FF00;
            4'd5:    c = 32'h00FF_0000;
            default: c = 32'hFF00_0000;
        endcase
        return c;
    endfunction

    // Every palette byte is 0x00 or 0xFF, so a channel either holds, ramps up
    // as floor(255k/n) or ramps down as 255 - ceil(255k/n).
    function automatic logic [CHAN_W-1:0] lerp_byte(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] q,
        input logic              rnz
    );
        logic [CHAN_W-1:0] v;
        if (a == b) begin
            v = a;
        end else if (b > a) begin
            v = q;
        end else begin
            v = 8'hFF - q - {{(CHAN_W-1){1'b0}}, rnz};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/rcf_div.sv]
// ============================================================================
// rcf_div - bit-serial restoring divider
// Computes floor(255*k / n) and flags a nonzero remainder, one quotient bit
// per cycle.
// ============================================================================
`default_nettype none

module rcf_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rcf_pkg::t_div_req   i_req,
    output rcf_pkg::t_div_res   o_res
);

    localparam int unsigned DVD_W = rcf_pkg::STEP_W + rcf_pkg::CHAN_W;
    localparam int unsigned CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [rcf_pkg::STEP_W-1:0] r_rem, n_rem;
    logic [rcf_pkg::STEP_W-1:0] r_dsr;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [rcf_pkg::STEP_W:0]   w_trial;
    logic [rcf_pkg::STEP_W+1:0] w_diff;
    logic                       w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_ge    = ~w_diff[rcf_pkg::STEP_W+1];

    always_comb begin
        if (i_req.start) begin
            // 255*k = (k << 8) - k
            n_dvd = {i_req.k, {rcf_pkg::CHAN_W{1'b0}}}
                  - {{rcf_pkg::CHAN_W{1'b0}}, i_req.k};
            n_rem = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DVD_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[rcf_pkg::STEP_W-1:0] : w_trial[rcf_pkg::STEP_W-1:0];
        end else begin
            n_dvd = r_dvd;
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_dsr <= i_req.n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_dvd[rcf_pkg::CHAN_W-1:0];
    assign o_res.rem_nz = |r_rem;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a finished run");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_dvd[DVD_W-1:rcf_pkg::CHAN_W] == '0)
        else $error("quotient exceeds one channel");

    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_dsr)
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

[rtl/rgb_color_flow_fader_core.sv]
// ============================================================================
// rgb_color_flow_fader_core - palette color flow with a work-mode alpha ramp
// ----------------------------------------------------------------------------
// One request on the s_axis channel is one millisecond tick; tdata bit 0 is
// the work-mode flag. Each tick yields exactly one ARGB result on m_axis:
// tdata = {4'b0, segment_now[3:0], argb[31:0]}, tuser = in_work_fade.
// Flow mode walks the palette, interpolating each channel over flow_steps
// ticks; work mode ramps alpha over pure green across work_steps ticks.
// Tick state is updated at acceptance; the channel values come from a single
// bit-serial divider that resolves one quotient bit per cycle for 255*k / n.
// s_axis_tready is high only in the idle state, so a new tick is taken only
// once the previous result has been loaded into the output register.
// The result sits in an output register, so the next tick is accepted while
// it waits; if the receiver stalls, the following result holds in the core
// and s_axis_tready stays low until the output register frees.
// Synchronous active-low reset returns to flow segment 0, step 0, restores
// flow_steps = 1000 and work_steps = 100, and drops m_axis_tvalid.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) take effect at the
// edge they are presented and are intended only while the core is idle.
// ============================================================================
`default_nettype none

module rgb_color_flow_fader_core #(
    parameter int unsigned PALETTE_LENGTH = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire         i_cfg_addr,
    input  wire  [15:0] i_cfg_wdata,
    // tick requests
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] work_mode, [7:1] zero
    // color results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] argb, [35:32] segment_now, [39:36] zero
    output logic        m_axis_tuser    // [0] in_work_fade
);

    localparam int unsigned SEG_W = rcf_pkg::SEG_W;
    localparam int unsigned STP_W = rcf_pkg::STEP_W;
    localparam logic [SEG_W:0]   PAL_LEN  = (SEG_W+1)'(PALETTE_LENGTH);
    localparam logic [SEG_W-1:0] PAL_LAST = SEG_W'(PALETTE_LENGTH - 1);

    rcf_pkg::t_state r_state, n_state;

    logic [STP_W-1:0] r_flow_steps, r_work_steps;
    logic             r_fading;
    logic [SEG_W-1:0] r_seg;
    logic [STP_W-1:0] r_step;

    logic             r_work;
    logic [SEG_W-1:0] r_seg_out;
    logic [rcf_pkg::COLOR_W-1:0] r_from, r_to;

    logic             r_m_valid;
    logic [rcf_pkg::COLOR_W-1:0] r_m_argb;
    logic [SEG_W-1:0] r_m_seg;
    logic             r_m_user;

    logic             w_accept, w_out_free, w_load;
    logic             w_work_now;
    logic [STP_W-1:0] w_n, w_k;
    logic [STP_W:0]   w_k_raw;
    logic             w_last;
    logic [SEG_W-1:0] w_seg_c, w_seg_to;
    logic [SEG_W:0]   w_seg_inc;
    logic             w_wrap;
    logic [rcf_pkg::COLOR_W-1:0] w_argb;

    rcf_pkg::t_div_req w_req;
    rcf_pkg::t_div_res w_res;

    // ---------------------------------------------------------------- tick math
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_work_now = r_fading || s_axis_tdata[0];

    always_comb begin
        if (w_work_now) begin
            w_n = (r_work_steps == '0) ? STP_W'(1) : r_work_steps;
        end else begin
            w_n = (r_flow_steps == '0) ? STP_W'(1) : r_flow_steps;
        end
        // entering the work ramp restarts the step count
        w_k_raw = (r_fading || !w_work_now) ? ({1'b0, r_step} + 1'b1) : (STP_W+1)'(1);
        w_last  = w_k_raw >= {1'b0, w_n};
        w_k     = w_last ? w_n : w_k_raw[STP_W-1:0];
    end

    assign w_seg_c   = ({1'b0, r_seg} >= PAL_LEN) ? PAL_LAST : r_seg;
    assign w_seg_inc = {1'b0, w_seg_c} + 1'b1;
    assign w_wrap    = w_seg_inc >= PAL_LEN;
    assign w_seg_to  = w_wrap ? '0 : w_seg_inc[SEG_W-1:0];

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_steps <= rcf_pkg::FLOW_STEPS_RST;
            r_work_steps <= rcf_pkg::WORK_STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rcf_pkg::CFG_FLOW_STEPS: r_flow_steps <= i_cfg_wdata;
                rcf_pkg::CFG_WORK_STEPS: r_work_steps <= i_cfg_wdata;
                default:                 r_flow_steps <= r_flow_steps;
            endcase
        end
    end

    // ---------------------------------------------------------------- tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fading <= 1'b0;
            r_seg    <= '0;
            r_step   <= '0;
        end else if (w_accept) begin
            if (w_work_now) begin
                r_seg    <= '0;
                r_fading <= !w_last;
                r_step   <= w_last ? '0 : w_k;
            end else begin
                r_step <= w_last ? '0 : w_k;
                r_seg  <= w_last ? w_seg_to : w_seg_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work    <= w_work_now;
            r_seg_out <= w_work_now ? '0 : w_seg_c;
            r_from    <= rcf_pkg::palette(w_seg_c);
            r_to      <= rcf_pkg::palette(w_seg_to);
        end
    end

    // ---------------------------------------------------------------- divider
    assign w_req.start = w_accept;
    assign w_req.k     = w_k;
    assign w_req.n     = w_n;

    rcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // ---------------------------------------------------------------- control
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcf_pkg::ST_IDLE: if (w_accept)    n_state = rcf_pkg::ST_DIV;
            rcf_pkg::ST_DIV:  if (w_res.done)  n_state = w_out_free ? rcf_pkg::ST_IDLE
                                                                    : rcf_pkg::ST_HOLD;
            rcf_pkg::ST_HOLD: if (w_out_free)  n_state = rcf_pkg::ST_IDLE;
            default:                           n_state = rcf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            rcf_pkg::ST_IDLE: s_axis_tready = 1'b1;
            rcf_pkg::ST_DIV:  w_load        = w_res.done && w_out_free;
            rcf_pkg::ST_HOLD: w_load        = w_out_free;
            default:          s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb begin
        if (r_work) begin
            w_argb = {w_res.quot, rcf_pkg::WORK_COLOR[23:0]};
        end else begin
            for (int i = 0; i < 4; i++) begin
                w_argb[i*8 +: 8] = rcf_pkg::lerp_byte(r_from[i*8 +: 8], r_to[i*8 +: 8],
                                                      w_res.quot, w_res.rem_nz);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_argb <= w_argb;
            r_m_seg  <= r_seg_out;
            r_m_user <= r_work;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_m_seg, r_m_argb};
    assign m_axis_tuser  = r_m_user;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> r_state == rcf_pkg::ST_DIV)
        else $error("divider finished outside a tick");

    a_work_seg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_user |-> r_m_seg == '0)
        else $error("work ramp result carries a segment");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> {1'b0, r_seg} < PAL_LEN)
        else $error("segment index left the palette");

endmodule

`default_nettype wire
